[design/btlv_pkg.sv]
// Shared constants and codes for the BER TLV deframer.
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

    // Long-form length byte count supported by default
    localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

    // Reset value of the value-length limit (128 KiB)
    localparam logic [31:0] MAX_VALUE_LENGTH_RST = 32'(2 << 16);

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ROLE_W  = 2;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned ERR_W   = 2;

    // m_tdata layout, lowest bit up: out_byte, tag_value, value_length, error_code
    localparam int unsigned TD_BYTE_LSB = 0;
    localparam int unsigned TD_TAG_LSB  = TD_BYTE_LSB + BYTE_W;
    localparam int unsigned TD_LEN_LSB  = TD_TAG_LSB + BYTE_W;
    localparam int unsigned TD_ERR_LSB  = TD_LEN_LSB + LEN_W;
    localparam int unsigned TD_USED_W   = TD_ERR_LSB + ERR_W;
    localparam int unsigned M_TDATA_W   = ((TD_USED_W + 7) / 8) * 8;

    // Largest short-form length; mask of the long-form byte count
    localparam logic [7:0] SHORT_LEN_MAX = 8'd127;
    localparam logic [7:0] LONG_CNT_MASK = 8'b0111_1111;

    // Saturation threshold for the length shift
    localparam logic [31:0] LEN_SHIFT_MAX = 32'h00FF_FFFF;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_TAG   = 2'd0,
        ROLE_LEN   = 2'd1,
        ROLE_VALUE = 2'd2
    } role_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_INDEFINITE = 2'd1,
        ERR_LEN_BYTES  = 2'd2,
        ERR_OVER_LIMIT = 2'd3
    } err_t;

endpackage

`default_nettype wire

[design/ber_tlv_deframer.sv]
// Top level of the BER TLV deframer: byte classifier, length decoder and output register.
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial deframer for back-to-back BER TLVs with single-byte tags. Every
// byte taken on s_ comes out once on m_, registered, labelled with its
// role (tag, length, value) in m_tuser, along with the tag of the TLV in
// progress, the length decoded so far and an error code; m_tlast marks the
// byte that completes a TLV. Short-form lengths run 0..127, long form takes
// 1..MAX_LENGTH_BYTES big-endian bytes. Errors (indefinite length 0x80, too
// many length bytes, length above max_value_length) are reported on the
// offending length byte with m_tlast low, and parsing resumes at a tag.
// Throughput is one item per clock while m_tready is high: the whole state
// update (one 32-bit shift/compare against the limit, one 32-bit down-count)
// sits between the state registers and the output register. The output
// register holds a result while m_tready is low and a new item is taken in
// the same cycle that the old one leaves. cfg_wr_en writes max_value_length;
// write it only while the block is idle.
module ber_tlv_deframer #(
    parameter int unsigned MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: max_value_length
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [btlv_pkg::M_TDATA_W-1:0] m_tdata,
        // [7:0] out_byte, [15:8] tag_value, [47:16] value_length,
        // [49:48] error_code, rest zero
    output logic [1:0]       m_tuser,   // [1:0] role
    output logic             m_tlast    // tlv_end
);

    // Remaining long-form length bytes; must hold MAX_LENGTH_BYTES itself
    localparam int unsigned LBW = $clog2(MAX_LENGTH_BYTES + 1);

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN1 = 2'd1,
        PH_LENN = 2'd2,
        PH_VAL  = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [31:0] accum_reg, accum_next;
    logic [LBW-1:0] lbl_reg, lbl_next, lbl_dec;
    logic [31:0] vbl_reg, vbl_next, vbl_dec;
    logic [31:0] max_len_reg;

    logic        m_tvalid_reg;
    logic [btlv_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;

    btlv_pkg::role_t role;
    btlv_pkg::err_t  err;
    logic        tlv_end;
    logic        len_done;
    logic        s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        accum_next = accum_reg;
        lbl_next   = lbl_reg;
        vbl_next   = vbl_reg;
        lbl_dec    = (lbl_reg != '0) ? lbl_reg - LBW'(1) : lbl_reg;
        vbl_dec    = (vbl_reg != '0) ? vbl_reg - 32'd1 : vbl_reg;
        role       = btlv_pkg::ROLE_TAG;
        err        = btlv_pkg::ERR_NONE;
        tlv_end    = 1'b0;
        len_done   = 1'b0;

        unique case (phase_reg)
            PH_TAG: begin
                role       = btlv_pkg::ROLE_TAG;
                tag_next   = s_tdata;
                accum_next = '0;
                lbl_next   = '0;
                vbl_next   = '0;
                phase_next = PH_LEN1;
            end
            PH_LEN1: begin
                role       = btlv_pkg::ROLE_LEN;
                accum_next = '0;
                if (s_tdata <= btlv_pkg::SHORT_LEN_MAX) begin
                    accum_next = {24'd0, s_tdata};
                    len_done   = 1'b1;
                end else if ((s_tdata & btlv_pkg::LONG_CNT_MASK) == 8'd0) begin
                    // indefinite length
                    err        = btlv_pkg::ERR_INDEFINITE;
                    phase_next = PH_TAG;
                end else if (32'(s_tdata & btlv_pkg::LONG_CNT_MASK) >
                             32'(MAX_LENGTH_BYTES)) begin
                    err        = btlv_pkg::ERR_LEN_BYTES;
                    phase_next = PH_TAG;
                end else begin
                    lbl_next   = s_tdata[LBW-1:0];
                    phase_next = PH_LENN;
                end
            end
            PH_LENN: begin
                role       = btlv_pkg::ROLE_LEN;
                // saturate when another byte would overflow 32 bits
                accum_next = (accum_reg > btlv_pkg::LEN_SHIFT_MAX) ? '1
                                                                   : {accum_reg[23:0], s_tdata};
                lbl_next   = lbl_dec;
                if (lbl_dec == '0) begin
                    len_done = 1'b1;
                end
            end
            PH_VAL: begin
                role     = btlv_pkg::ROLE_VALUE;
                vbl_next = vbl_dec;
                if (vbl_dec == '0) begin
                    tlv_end    = 1'b1;
                    phase_next = PH_TAG;
                end
            end
            default: begin
                phase_next = PH_TAG;
            end
        endcase

        // length complete: limit check, empty value, or start of value bytes
        if (len_done) begin
            if (accum_next > max_len_reg) begin
                err        = btlv_pkg::ERR_OVER_LIMIT;
                phase_next = PH_TAG;
            end else if (accum_next == '0) begin
                tlv_end    = 1'b1;
                phase_next = PH_TAG;
            end else begin
                vbl_next   = accum_next;
                phase_next = PH_VAL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TAG;
            tag_reg      <= '0;
            accum_reg    <= '0;
            lbl_reg      <= '0;
            vbl_reg      <= '0;
            max_len_reg  <= btlv_pkg::MAX_VALUE_LENGTH_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                phase_reg    <= phase_next;
                tag_reg      <= tag_next;
                accum_reg    <= accum_next;
                lbl_reg      <= lbl_next;
                vbl_reg      <= vbl_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= btlv_pkg::M_TDATA_W'({err, accum_next, tag_next, s_tdata});
            m_tuser_reg <= role;
            m_tlast_reg <= tlv_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

[design/btlv_checker.sv]
// Port-level assertion checker for the BER TLV deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module btlv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [btlv_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    logic [7:0]  out_byte;
    logic [7:0]  tag_val;
    logic [31:0] val_len;
    logic [1:0]  err_code;

    assign out_byte = m_tdata[btlv_pkg::TD_BYTE_LSB +: 8];
    assign tag_val  = m_tdata[btlv_pkg::TD_TAG_LSB +: 8];
    assign val_len  = m_tdata[btlv_pkg::TD_LEN_LSB +: 32];
    assign err_code = m_tdata[btlv_pkg::TD_ERR_LSB +: 2];

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // error items never close a TLV
    a_err_no_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err_code != btlv_pkg::ERR_NONE
            |-> !m_tlast && m_tuser == btlv_pkg::ROLE_LEN)
        else $error("error flagged on a non-length item or with tlast");

    // a tag item carries its own byte as tag and a cleared length
    a_tag_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == btlv_pkg::ROLE_TAG |-> tag_val == out_byte && val_len == '0
                                                      && !m_tlast)
        else $error("tag item fields wrong");

    // an item is taken whenever the output stage is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // nothing valid right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ber_tlv_deframer btlv_checker u_btlv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
